FILE: hdl/psar_pkg.sv
// Package with shared types and operation codes for the scroll address register.
`timescale 1ns / 1ps

package psar_pkg;

    localparam logic [3:0] OP_CTRL_WRITE   = 4'd0;
    localparam logic [3:0] OP_SCROLL_WRITE = 4'd1;
    localparam logic [3:0] OP_ADDR_WRITE   = 4'd2;
    localparam logic [3:0] OP_STATUS_READ  = 4'd3;
    localparam logic [3:0] OP_DATA_ACCESS  = 4'd4;
    localparam logic [3:0] OP_INC_X        = 4'd5;
    localparam logic [3:0] OP_INC_Y        = 4'd6;
    localparam logic [3:0] OP_COPY_X       = 4'd7;
    localparam logic [3:0] OP_COPY_Y       = 4'd8;

    // Coarse y values that end a nametable row count, and the largest fine y and coarse x values.
    localparam logic [4:0] CY_LAST_ROW = 5'd29;
    localparam logic [4:0] CY_MAX      = 5'd31;
    localparam logic [2:0] FY_MAX      = 3'd7;
    localparam logic [4:0] CX_MAX      = 5'd31;

    typedef struct packed {
        logic [3:0] operation;
        logic [7:0] data_byte;
        logic       rendering;
    } item_t;

    typedef struct packed {
        logic [13:0] access_address;
        logic [14:0] current_address;
        logic [13:0] nametable_address;
        logic [13:0] attribute_address;
        logic [1:0]  attribute_shift;
        logic [2:0]  fine_x;
        logic        write_toggle;
    } result_t;

endpackage

FILE: hdl/psar_in_stage.sv
// Input register stage that captures one operation transaction.
`timescale 1ns / 1ps

module psar_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  psar_pkg::item_t in_item,
    output logic            item_valid,
    input  logic            item_take,
    output psar_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    psar_pkg::item_t item_reg;

    // The stage can load whenever it is empty or its item leaves this cycle.
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: hdl/psar_core.sv
// Address, temporary address, fine x, toggle and step registers with update logic.
`timescale 1ns / 1ps

module psar_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  psar_pkg::item_t   item,
    output psar_pkg::result_t result
);

    logic [14:0] vaddr_reg;
    logic [14:0] vaddr_next;
    logic [14:0] taddr_reg;
    logic [14:0] taddr_next;
    logic [2:0]  fine_x_reg;
    logic [2:0]  fine_x_next;
    logic        toggle_reg;
    logic        toggle_next;
    logic        step32_reg;
    logic        step32_next;
    logic [13:0] access;
    logic [14:0] v_bump_y;
    logic [14:0] linear_step;

    // Horizontal tile step: wrapping coarse x flips the horizontal nametable.
    function automatic logic [14:0] bump_x(input logic [14:0] v);
        logic [14:0] r;
        r = v;
        if (v[4:0] == psar_pkg::CX_MAX)
        begin
            r[4:0] = 5'd0;
            r[10]  = ~v[10];
        end
        else
        begin
            r[4:0] = v[4:0] + 5'd1;
        end
        return r;
    endfunction

    // Vertical step: fine y first, then coarse y with the row 29 wrap.
    function automatic logic [14:0] bump_y(input logic [14:0] v);
        logic [14:0] r;
        r = v;
        if (v[14:12] != psar_pkg::FY_MAX)
        begin
            r[14:12] = v[14:12] + 3'd1;
        end
        else
        begin
            r[14:12] = 3'd0;
            if (v[9:5] == psar_pkg::CY_LAST_ROW)
            begin
                r[9:5] = 5'd0;
                r[11]  = ~v[11];
            end
            else if (v[9:5] == psar_pkg::CY_MAX)
            begin
                r[9:5] = 5'd0;
            end
            else
            begin
                r[9:5] = v[9:5] + 5'd1;
            end
        end
        return r;
    endfunction

    assign v_bump_y    = bump_y(vaddr_reg);
    assign linear_step = vaddr_reg + (step32_reg ? 15'd32 : 15'd1);

    always_comb
    begin
        vaddr_next  = vaddr_reg;
        taddr_next  = taddr_reg;
        fine_x_next = fine_x_reg;
        toggle_next = toggle_reg;
        step32_next = step32_reg;
        access      = 14'd0;
        unique case (item.operation)
            psar_pkg::OP_CTRL_WRITE:
            begin
                taddr_next[11:10] = item.data_byte[1:0];
                step32_next       = item.data_byte[2];
            end
            psar_pkg::OP_SCROLL_WRITE:
            begin
                if (!toggle_reg)
                begin
                    taddr_next[4:0] = item.data_byte[7:3];
                    fine_x_next     = item.data_byte[2:0];
                end
                else
                begin
                    taddr_next[9:5]   = item.data_byte[7:3];
                    taddr_next[14:12] = item.data_byte[2:0];
                end
                toggle_next = ~toggle_reg;
            end
            psar_pkg::OP_ADDR_WRITE:
            begin
                if (!toggle_reg)
                begin
                    taddr_next[13:8] = item.data_byte[5:0];
                    taddr_next[14]   = 1'b0;
                end
                else
                begin
                    taddr_next[7:0] = item.data_byte;
                    vaddr_next      = {taddr_reg[14:8], item.data_byte};
                end
                toggle_next = ~toggle_reg;
            end
            psar_pkg::OP_STATUS_READ:
            begin
                toggle_next = 1'b0;
            end
            psar_pkg::OP_DATA_ACCESS:
            begin
                access     = vaddr_reg[13:0];
                vaddr_next = item.rendering ? bump_x(v_bump_y) : linear_step;
            end
            psar_pkg::OP_INC_X:
            begin
                vaddr_next = bump_x(vaddr_reg);
            end
            psar_pkg::OP_INC_Y:
            begin
                vaddr_next = v_bump_y;
            end
            psar_pkg::OP_COPY_X:
            begin
                vaddr_next[4:0] = taddr_reg[4:0];
                vaddr_next[10]  = taddr_reg[10];
            end
            psar_pkg::OP_COPY_Y:
            begin
                vaddr_next[9:5]   = taddr_reg[9:5];
                vaddr_next[11]    = taddr_reg[11];
                vaddr_next[14:12] = taddr_reg[14:12];
            end
            default:
            begin
                vaddr_next = vaddr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vaddr_reg  <= 15'd0;
            taddr_reg  <= 15'd0;
            fine_x_reg <= 3'd0;
            toggle_reg <= 1'b0;
            step32_reg <= 1'b0;
        end
        else if (fire)
        begin
            vaddr_reg  <= vaddr_next;
            taddr_reg  <= taddr_next;
            fine_x_reg <= fine_x_next;
            toggle_reg <= toggle_next;
            step32_reg <= step32_next;
        end
    end

    // Fetch addresses are derived from the updated video address.
    always_comb
    begin
        result.access_address    = access;
        result.current_address   = vaddr_next;
        result.nametable_address = {2'b10, vaddr_next[11:0]};
        result.attribute_address = {2'b10, vaddr_next[11:10], 4'b1111,
                                    vaddr_next[9:7], vaddr_next[4:2]};
        result.attribute_shift   = {vaddr_next[6], vaddr_next[1]};
        result.fine_x            = fine_x_next;
        result.write_toggle      = toggle_next;
    end

endmodule

FILE: hdl/psar_out_stage.sv
// Result register that holds one result transaction until it is taken.
`timescale 1ns / 1ps

module psar_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    output logic              space,
    input  psar_pkg::result_t result_in,
    output logic              out_valid,
    input  logic              out_ready,
    output psar_pkg::result_t result_out
);

    logic              valid_reg;
    logic              valid_next;
    psar_pkg::result_t result_reg;

    assign space      = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

FILE: hdl/ppu_scroll_address_register_core.sv
// Top level of the picture unit scroll and video address register pair.
`timescale 1ns / 1ps

// The block keeps the 15-bit current video address, the temporary address,
// the fine x scroll, the two-write toggle and the 1/32 increment step.
// Each input transaction carries one operation (control, scroll or address
// write, status read, data access, increment x or y, copy x or y) with its
// data byte and the rendering flag. Every input transaction yields exactly
// one result transaction with the updated address, the nametable and
// attribute fetch addresses, the attribute quadrant, fine x and the toggle.
// An operation first lands in the input register; from there the update
// logic applies it to the state and loads the result register as soon as
// that register has room, and the result is offered from the result register.
// One transaction is accepted every cycle while results are taken, which
// is set by the single update step between the two registers.
// When the receiver stalls, the result register holds its transaction and
// the input register can still take one more operation; in_ready drops
// only when both registers are full. Reset clears all state to zero and
// empties both registers.
module ppu_scroll_address_register_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  operation,
    input  logic [7:0]  data_byte,
    input  logic        rendering,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [13:0] access_address,
    output logic [14:0] current_address,
    output logic [13:0] nametable_address,
    output logic [13:0] attribute_address,
    output logic [1:0]  attribute_shift,
    output logic [2:0]  fine_x,
    output logic        write_toggle
);

    psar_pkg::item_t   in_item;
    psar_pkg::item_t   item;
    psar_pkg::result_t core_result;
    psar_pkg::result_t result;
    logic              item_valid;
    logic              out_space;
    logic              fire;

    assign in_item.operation = operation;
    assign in_item.data_byte = data_byte;
    assign in_item.rendering = rendering;

    // An operation is applied when it is held and the result register has room.
    assign fire = item_valid && out_space;

    psar_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (fire),
        .item       (item)
    );

    psar_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (core_result)
    );

    psar_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .space      (out_space),
        .result_in  (core_result),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (result)
    );

    assign access_address    = result.access_address;
    assign current_address   = result.current_address;
    assign nametable_address = result.nametable_address;
    assign attribute_address = result.attribute_address;
    assign attribute_shift   = result.attribute_shift;
    assign fine_x            = result.fine_x;
    assign write_toggle      = result.write_toggle;

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the scroll and video address register pair.
`timescale 1ns / 1ps

// The testbench runs a short table of hand-picked operations first. A few
// rows carry a typed-in result; the others are checked against a predictor
// of the address registers that lives in this module. After the table come
// about a thousand random operations. Most of them are grouped the way
// software and the renderer issue them: address write pairs followed by
// data accesses, scroll setup, and long runs of scroll increments and
// copies. A small share is noise: unused codes and write pairs that are
// broken off halfway.
// The random part runs in three idle profiles. First the sender idles
// seldom and the receiver often, then the other way round, and last
// neither side idles. In each profile the receiver holds off once for a
// long stretch so that the block fills up and drops in_ready. Later in the
// same profile the sender stops until every pending result has arrived.
// Every accepted input transaction is predicted at the clock edge that
// accepts it. Every accepted result transaction is compared with the oldest
// prediction. A watchdog ends the run when no transaction moves for a long
// time.
module testbench;

    // Codes that the block leaves without effect.
    localparam logic [3:0]  OP_SPARE_FIRST = 4'd9;
    localparam logic [3:0]  OP_SPARE_LAST  = 4'd15;

    localparam logic [13:0] NAMETABLE_BASE = 14'h2000;
    localparam logic [13:0] ATTRIBUTE_BASE = 14'h23C0;

    localparam int RANDOM_OPS   = 1000;
    localparam int LONG_HOLD    = 40;
    // The block has two register stages, so a stray result after the last
    // expected one shows up within the tail wait.
    localparam int TAIL_CYCLES  = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        psar_pkg::item_t   op_item;
        logic              checked;
        psar_pkg::result_t want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [3:0]  operation = '0;
    logic [7:0]  data_byte = '0;
    logic        rendering = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [13:0] access_address;
    logic [14:0] current_address;
    logic [13:0] nametable_address;
    logic [13:0] attribute_address;
    logic [1:0]  attribute_shift;
    logic [2:0]  fine_x;
    logic        write_toggle;

    // A typed-in expectation goes with the payload. It is driven at the
    // same edge as the payload, so the monitor sees both together.
    logic              row_checked = 1'b0;
    psar_pkg::result_t row_want = '0;

    // Predictor copy of the register state.
    logic [14:0] vaddr_model = '0;
    logic [14:0] taddr_model = '0;
    logic [2:0]  fine_x_model = '0;
    logic        toggle_model = 1'b0;
    logic        step32_model = 1'b0;

    psar_pkg::result_t pending_results[$];
    plan_row_t         directed_rows[$];
    int                mismatches = 0;
    int                ops_sent = 0;
    int                tx_idle_pct = 0;
    int                rx_idle_pct = 0;
    int                hold_requests = 0;
    bit                drain_pending = 1'b0;

    ppu_scroll_address_register_core DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .operation         (operation),
        .data_byte         (data_byte),
        .rendering         (rendering),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .access_address    (access_address),
        .current_address   (current_address),
        .nametable_address (nametable_address),
        .attribute_address (attribute_address),
        .attribute_shift   (attribute_shift),
        .fine_x            (fine_x),
        .write_toggle      (write_toggle)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Horizontal step. At the last column, coarse x wraps and the next
    // nametable to the side is selected.
    function automatic logic [14:0] step_coarse_x(input logic [14:0] a);
        logic [14:0] n;
        n = a;
        if (a[4:0] == psar_pkg::CX_MAX)
        begin
            n[4:0] = '0;
            n[10] = ~a[10];
        end
        else
        begin
            n[4:0] = a[4:0] + 5'd1;
        end
        return n;
    endfunction

    // Vertical step. Fine y counts first. Coarse y then wraps at row 29
    // into the other nametable. Rows 30 and 31 hold attribute data, and from
    // row 31 coarse y wraps without changing the nametable.
    function automatic logic [14:0] step_fine_y(input logic [14:0] a);
        logic [14:0] n;
        n = a;
        if (a[14:12] != psar_pkg::FY_MAX)
        begin
            n[14:12] = a[14:12] + 3'd1;
        end
        else
        begin
            n[14:12] = '0;
            if (a[9:5] == psar_pkg::CY_LAST_ROW)
            begin
                n[9:5] = '0;
                n[11] = ~a[11];
            end
            else if (a[9:5] == psar_pkg::CY_MAX)
            begin
                n[9:5] = '0;
            end
            else
            begin
                n[9:5] = a[9:5] + 5'd1;
            end
        end
        return n;
    endfunction

    // Applies one operation to the predictor state and returns the result
    // transaction that the block should produce for it.
    function automatic psar_pkg::result_t advance_registers(input psar_pkg::item_t it);
        psar_pkg::result_t r;
        logic [14:0]       v_before;
        v_before = vaddr_model;
        case (it.operation)
            psar_pkg::OP_CTRL_WRITE:
            begin
                taddr_model[11:10] = it.data_byte[1:0];
                step32_model = it.data_byte[2];
            end
            psar_pkg::OP_SCROLL_WRITE:
            begin
                if (!toggle_model)
                begin
                    taddr_model[4:0] = it.data_byte[7:3];
                    fine_x_model = it.data_byte[2:0];
                end
                else
                begin
                    taddr_model[9:5] = it.data_byte[7:3];
                    taddr_model[14:12] = it.data_byte[2:0];
                end
                toggle_model = ~toggle_model;
            end
            psar_pkg::OP_ADDR_WRITE:
            begin
                if (!toggle_model)
                begin
                    taddr_model[13:8] = it.data_byte[5:0];
                    taddr_model[14] = 1'b0;
                end
                else
                begin
                    taddr_model[7:0] = it.data_byte;
                    vaddr_model = taddr_model;
                end
                toggle_model = ~toggle_model;
            end
            psar_pkg::OP_STATUS_READ:
            begin
                toggle_model = 1'b0;
            end
            psar_pkg::OP_DATA_ACCESS:
            begin
                // While rendering, an access moves the scroll position
                // instead of stepping the address linearly.
                if (it.rendering)
                    vaddr_model = step_coarse_x(step_fine_y(vaddr_model));
                else
                    vaddr_model = vaddr_model + (step32_model ? 15'd32 : 15'd1);
            end
            psar_pkg::OP_INC_X:
            begin
                vaddr_model = step_coarse_x(vaddr_model);
            end
            psar_pkg::OP_INC_Y:
            begin
                vaddr_model = step_fine_y(vaddr_model);
            end
            psar_pkg::OP_COPY_X:
            begin
                vaddr_model[4:0] = taddr_model[4:0];
                vaddr_model[10] = taddr_model[10];
            end
            psar_pkg::OP_COPY_Y:
            begin
                vaddr_model[9:5] = taddr_model[9:5];
                vaddr_model[11] = taddr_model[11];
                vaddr_model[14:12] = taddr_model[14:12];
            end
            default:
            begin
            end
        endcase
        r.access_address = (it.operation == psar_pkg::OP_DATA_ACCESS) ? v_before[13:0] : '0;
        r.current_address = vaddr_model;
        r.nametable_address = NAMETABLE_BASE | {2'b00, vaddr_model[11:0]};
        r.attribute_address = ATTRIBUTE_BASE | {2'b00, vaddr_model[11:10], 10'b0}
                            | {8'b0, vaddr_model[9:7], vaddr_model[4:2]};
        r.attribute_shift = {vaddr_model[6], vaddr_model[1]};
        r.fine_x = fine_x_model;
        r.write_toggle = toggle_model;
        return r;
    endfunction

    function automatic string describe(input psar_pkg::result_t r);
        return {$sformatf("access=%h current=%h nametable=%h attribute=%h ",
                          r.access_address, r.current_address, r.nametable_address,
                          r.attribute_address),
                $sformatf("shift=%0d fine_x=%0d toggle=%0d",
                          r.attribute_shift, r.fine_x, r.write_toggle)};
    endfunction

    function automatic psar_pkg::item_t make_op(input logic [3:0] op, input logic [7:0] d,
                                                input logic rend);
        psar_pkg::item_t it;
        it.operation = op;
        it.data_byte = d;
        it.rendering = rend;
        return it;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [3:0] rand_code();
        return 4'($urandom_range(0, 15));
    endfunction

    // Both handshakes are watched here. Signals are sampled at the edge
    // that accepts the transaction, before any of this edge's updates land.
    // The result side is checked first, so a result cannot be matched with
    // an input that is accepted at the same edge.
    always @(posedge clk)
    begin
        psar_pkg::result_t got;
        psar_pkg::result_t want;
        logic              bad;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {access_address, current_address, nametable_address,
                       attribute_address, attribute_shift, fine_x, write_toggle};
                if (pending_results.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("Unexpected result at %0t: %s", $realtime, describe(got));
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    bad = (got.access_address !== want.access_address)
                        || (got.current_address !== want.current_address)
                        || (got.nametable_address !== want.nametable_address)
                        || (got.attribute_address !== want.attribute_address)
                        || (got.attribute_shift !== want.attribute_shift)
                        || (got.fine_x !== want.fine_x)
                        || (got.write_toggle !== want.write_toggle);
                    if (bad)
                    begin
                        if (mismatches < REPORT_LIMIT)
                        begin
                            $display("Mismatch at %0t", $realtime);
                            $display("  expected %s", describe(want));
                            $display("  actual   %s", describe(got));
                        end
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                want = advance_registers(make_op(operation, data_byte, rendering));
                // A typed-in row replaces the prediction, but the predictor
                // state still moves along with the block.
                if (row_checked)
                    want = row_want;
                pending_results.push_back(want);
            end
        end
    end

    // The receiver drives out_ready once per edge. A long hold-off is
    // requested by the stimulus process and counted out here.
    initial
    begin : receiver
        int holds_seen;
        int hold_left;
        holds_seen = 0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Ends the run when no transaction has moved on either side for a
    // long time.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("No transaction for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Offers one operation and returns at the edge that accepts it. Every
    // call starts at a clock edge. When the sender goes idle, in_valid is
    // lowered and held low across the idle clock edges before it rises again.
    task automatic offer(input psar_pkg::item_t it, input logic checked,
                         input psar_pkg::result_t want);
        int gap;
        bit drain;
        gap = 0;
        drain = drain_pending;
        drain_pending = 1'b0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (drain || gap > 0)
        begin
            in_valid <= 1'b0;
            if (drain)
            begin
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
            end
            repeat (gap) @(posedge clk);
        end
        operation <= it.operation;
        data_byte <= it.data_byte;
        rendering <= it.rendering;
        row_checked <= checked;
        row_want <= want;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Only the defined codes count toward the size of the random part.
    task automatic send_random(input psar_pkg::item_t it);
        offer(it, 1'b0, '0);
        if (it.operation <= psar_pkg::OP_COPY_Y)
            ops_sent++;
    endtask

    task automatic plan(input logic [3:0] op, input logic [7:0] d, input logic rend);
        directed_rows.push_back({make_op(op, d, rend), 1'b0, psar_pkg::result_t'('0)});
    endtask

    task automatic plan_checked(input logic [3:0] op, input logic [7:0] d, input logic rend,
                                input psar_pkg::result_t want);
        directed_rows.push_back({make_op(op, d, rend), 1'b1, want});
    endtask

    // Random operations grouped the way software and the renderer use the
    // registers, with some noise and some write pairs broken off halfway.
    task automatic run_random_sequence();
        int kind;
        int n;
        int pick;
        kind = $urandom_range(0, 9);
        if (kind <= 1)
        begin
            // Set an address, then stream data through it.
            if ($urandom_range(0, 3) != 0)
                send_random(make_op(psar_pkg::OP_STATUS_READ, rand_byte(), rand_bit()));
            send_random(make_op(psar_pkg::OP_ADDR_WRITE, rand_byte(), rand_bit()));
            send_random(make_op(psar_pkg::OP_ADDR_WRITE, rand_byte(), rand_bit()));
            n = $urandom_range(1, 6);
            repeat (n)
                send_random(make_op(psar_pkg::OP_DATA_ACCESS, rand_byte(), rand_bit()));
        end
        else if (kind <= 3)
        begin
            // Scroll setup as done before a frame, then the copies the
            // renderer makes.
            send_random(make_op(psar_pkg::OP_STATUS_READ, rand_byte(), rand_bit()));
            send_random(make_op(psar_pkg::OP_CTRL_WRITE, rand_byte(), rand_bit()));
            send_random(make_op(psar_pkg::OP_SCROLL_WRITE, rand_byte(), rand_bit()));
            send_random(make_op(psar_pkg::OP_SCROLL_WRITE, rand_byte(), rand_bit()));
            send_random(make_op(psar_pkg::OP_COPY_Y, rand_byte(), rand_bit()));
            send_random(make_op(psar_pkg::OP_COPY_X, rand_byte(), rand_bit()));
        end
        else if (kind <= 6)
        begin
            // A stretch of rendering. The share of vertical steps is high
            // enough to carry fine y and coarse y through their wraps.
            n = $urandom_range(4, 40);
            repeat (n)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    send_random(make_op(psar_pkg::OP_INC_X, rand_byte(), rand_bit()));
                else if (pick < 70)
                    send_random(make_op(psar_pkg::OP_INC_Y, rand_byte(), rand_bit()));
                else if (pick < 85)
                    send_random(make_op(psar_pkg::OP_DATA_ACCESS, rand_byte(), 1'b1));
                else if (pick < 93)
                    send_random(make_op(psar_pkg::OP_COPY_X, rand_byte(), rand_bit()));
                else
                    send_random(make_op(psar_pkg::OP_COPY_Y, rand_byte(), rand_bit()));
            end
        end
        else if (kind <= 8)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
                send_random(make_op(rand_code(), rand_byte(), rand_bit()));
        end
        else
        begin
            // Half of a write pair followed by anything at all.
            if ($urandom_range(0, 1))
                send_random(make_op(psar_pkg::OP_ADDR_WRITE, rand_byte(), rand_bit()));
            else
                send_random(make_op(psar_pkg::OP_SCROLL_WRITE, rand_byte(), rand_bit()));
            send_random(make_op(rand_code(), rand_byte(), rand_bit()));
        end
    endtask

    initial
    begin : stimulus
        int        phase;
        int        target;
        int        per_phase;
        bit        hold_sent;
        bit        pause_sent;
        plan_row_t row;

        // Rows with a typed-in result list access, current, nametable,
        // attribute, shift, fine x and toggle in that order.
        plan_checked(psar_pkg::OP_STATUS_READ, 8'h00, 1'b0,
                     {14'h0000, 15'h0000, 14'h2000, 14'h23C0, 2'd0, 3'd0, 1'b0});
        // The first address write goes to the temporary register only.
        plan_checked(psar_pkg::OP_ADDR_WRITE, 8'hFF, 1'b0,
                     {14'h0000, 15'h0000, 14'h2000, 14'h23C0, 2'd0, 3'd0, 1'b1});
        // The second one loads the current address, at its largest value.
        plan_checked(psar_pkg::OP_ADDR_WRITE, 8'hFF, 1'b0,
                     {14'h0000, 15'h3FFF, 14'h2FFF, 14'h2FFF, 2'd3, 3'd0, 1'b0});
        plan_checked(psar_pkg::OP_DATA_ACCESS, 8'h00, 1'b0,
                     {14'h3FFF, 15'h4000, 14'h2000, 14'h23C0, 2'd0, 3'd0, 1'b0});
        plan(psar_pkg::OP_CTRL_WRITE, 8'hFF, 1'b0);
        plan(psar_pkg::OP_DATA_ACCESS, 8'h00, 1'b0);
        plan(psar_pkg::OP_STATUS_READ, 8'hFF, 1'b1);
        plan(psar_pkg::OP_SCROLL_WRITE, 8'hFF, 1'b0);
        plan(psar_pkg::OP_SCROLL_WRITE, 8'hFF, 1'b0);
        plan(psar_pkg::OP_COPY_X, 8'h00, 1'b0);
        plan_checked(psar_pkg::OP_COPY_Y, 8'h00, 1'b0,
                     {14'h0000, 15'h7FFF, 14'h2FFF, 14'h2FFF, 2'd3, 3'd7, 1'b0});
        // The linear step by 32 wraps within 15 bits.
        plan_checked(psar_pkg::OP_DATA_ACCESS, 8'h00, 1'b0,
                     {14'h3FFF, 15'h001F, 14'h201F, 14'h23C7, 2'd1, 3'd7, 1'b0});
        // Vertical step from row 31 at the last fine y wraps without a
        // nametable flip. The horizontal step at column 31 flips one.
        plan(psar_pkg::OP_COPY_Y, 8'h00, 1'b0);
        plan(psar_pkg::OP_INC_Y, 8'hFF, 1'b1);
        plan(psar_pkg::OP_INC_X, 8'hFF, 1'b1);
        // Row 29 at the last fine y wraps into the other nametable.
        plan(psar_pkg::OP_STATUS_READ, 8'h00, 1'b0);
        plan(psar_pkg::OP_SCROLL_WRITE, 8'h00, 1'b0);
        plan(psar_pkg::OP_SCROLL_WRITE, 8'hEF, 1'b0);
        plan(psar_pkg::OP_COPY_Y, 8'h00, 1'b0);
        plan(psar_pkg::OP_INC_Y, 8'h00, 1'b0);
        // A data access while rendering, with a byte that must be ignored.
        plan(psar_pkg::OP_DATA_ACCESS, 8'hAA, 1'b1);
        // Unused codes leave the state alone.
        plan(OP_SPARE_FIRST, 8'hFF, 1'b1);
        plan(OP_SPARE_LAST, 8'hFF, 1'b1);
        plan(psar_pkg::OP_CTRL_WRITE, 8'h00, 1'b0);
        plan(psar_pkg::OP_DATA_ACCESS, 8'h55, 1'b0);
        // A status read clears a toggle left at one.
        plan(psar_pkg::OP_SCROLL_WRITE, 8'h5A, 1'b0);
        plan(psar_pkg::OP_STATUS_READ, 8'h00, 1'b0);

        tx_idle_pct = 11;
        rx_idle_pct = 73;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            offer(row.op_item, row.checked, row.want);
        end

        per_phase = RANDOM_OPS / 3;
        for (phase = 0; phase < 3; phase++)
        begin
            if (phase == 0)
            begin
                tx_idle_pct = 11;
                rx_idle_pct = 73;
            end
            else if (phase == 1)
            begin
                tx_idle_pct = 73;
                rx_idle_pct = 11;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            target = ops_sent + per_phase;
            hold_sent = 1'b0;
            pause_sent = 1'b0;
            while (ops_sent < target)
            begin
                // Halfway through, the receiver stops for a long stretch
                // while the sender keeps offering operations.
                if (!hold_sent && ops_sent >= target - per_phase / 2)
                begin
                    hold_requests <= hold_requests + 1;
                    hold_sent = 1'b1;
                end
                // Later, the sender waits until the block has drained.
                if (!pause_sent && ops_sent >= target - per_phase / 4)
                begin
                    drain_pending = 1'b1;
                    pause_sent = 1'b1;
                end
                run_random_sequence();
            end
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
